// File: src/imu_dfr_pkg.sv
// ----------------------------------------------------------------------------
// imu_dfr_pkg
// Shared types and constants for the IMU frame deframer: frame layout,
// sync pattern, register indexes, hunter and sequencer encodings.
// ----------------------------------------------------------------------------
package imu_dfr_pkg;

	// Frame layout
	localparam int FRAME_LEN     = 32;
	localparam int ADDR_W        = $clog2(FRAME_LEN);
	localparam int PAYLOAD_BYTES = 29;	// bytes 2..30 hold the fields
	typedef logic [ADDR_W-1:0] addr_t;

	localparam logic [7:0] SYNC_FIRST  = 8'h55;
	localparam logic [7:0] SYNC_SECOND = 8'hAA;
	localparam addr_t      SEQ_POS     = addr_t'(2);	// first body byte
	localparam addr_t      PAYLOAD_END = addr_t'(30);	// last summed byte
	localparam addr_t      SUM_POS     = addr_t'(31);	// checksum byte

	// Sequence counter wrap used for the lost-frame count
	localparam int SEQ_MODULUS = 200;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ACCEL_OFF_X = 2'd0,
		CFG_ACCEL_OFF_Y = 2'd1,
		CFG_ACCEL_OFF_Z = 2'd2
	} cfg_idx_e;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} accel_off_t;

	// Sync hunter phase
	typedef enum logic [1:0] {
		PH_HUNT    = 2'd0,
		PH_SYNC1   = 2'd1,
		PH_COLLECT = 2'd2
	} hunt_phase_e;

	// Top-level sequencer
	typedef enum logic [2:0] {
		ST_RX         = 3'd0,
		ST_REPLAY     = 3'd1,
		ST_REPLAY_END = 3'd2,
		ST_UNPACK     = 3'd3,
		ST_UNPACK_END = 3'd4
	} seq_state_e;

	// Hunter result toward store and sequencer
	typedef struct packed {
		logic       wr_en;
		addr_t      wr_addr;
		logic [7:0] wr_data;
		logic       at_last;	// next body byte closes the frame
		logic       done;		// frame closed this cycle
		logic       pass;		// checksum matched
	} hunt_res_t;

	// Sequencer control toward the unpacker
	typedef struct packed {
		logic shift;
		logic load;
	} unp_ctl_t;

endpackage

// File: src/imu_dfr_if.sv
// ----------------------------------------------------------------------------
// imu_dfr_if
// Valid/ready channels of the deframer: received byte stream in, unpacked
// frame out.
// ----------------------------------------------------------------------------
interface imu_dfr_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface imu_dfr_frame_if;
	logic               valid;
	logic               ready;
	logic [7:0]         frame_seq;
	logic signed [15:0] gyro_x;
	logic signed [15:0] gyro_y;
	logic signed [15:0] gyro_z;
	logic signed [16:0] accel_x;
	logic signed [16:0] accel_y;
	logic signed [16:0] accel_z;
	logic signed [31:0] quat_w;
	logic signed [31:0] quat_x;
	logic signed [31:0] quat_y;
	logic signed [31:0] quat_z;
	logic [7:0]         lost_frames;

	modport source (output valid, output frame_seq, output gyro_x, output gyro_y,
		output gyro_z, output accel_x, output accel_y, output accel_z,
		output quat_w, output quat_x, output quat_y, output quat_z,
		output lost_frames, input ready);
	modport sink (input valid, input frame_seq, input gyro_x, input gyro_y,
		input gyro_z, input accel_x, input accel_y, input accel_z,
		input quat_w, input quat_x, input quat_y, input quat_z,
		input lost_frames, output ready);
endinterface

// File: src/imu_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// imu_frame_deframer_top
// Byte-serial deframer for 32-byte IMU frames with a 0x55 0xAA sync pair and
// an 8-bit sum checksum. Bad frames are replayed from the frame store through
// the sync hunter; good frames are unpacked from the store into fields.
//
//   Port       Dir  Handshake          Payload
//   rx         in   rx.valid/ready     rx_byte[7:0]
//   frame      out  frame.valid/ready  seq, gyro xyz, accel xyz, quat wxyz, lost
//   cfg_*      in   cfg_wr_en          cfg_index[1:0], cfg_wdata[15:0]
//
// One byte per cycle while rx.ready is high. After the byte that closes a frame,
// rx.ready stays low for the frame store reads (good frame: 29 reads to unpack;
// bad frame: 30 replay reads); the frame store's single read port sets this.
// Reset clears the hunter, sequencer, offsets and output valid; the frame
// store is not cleared. A result waits in the output register while bytes keep
// flowing; only the byte that would close the next frame is held off.
// ----------------------------------------------------------------------------
module imu_frame_deframer_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	imu_dfr_rx_if.sink                            rx,
	imu_dfr_frame_if.source                       frame,
	input  logic                                  cfg_wr_en,
	input  logic [imu_dfr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [imu_dfr_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import imu_dfr_pkg::*;

	seq_state_e state_q, state_d;
	addr_t      idx_q, idx_d;
	logic       rd_pend_s1;
	logic       rd_en;
	logic [7:0] rd_data;
	logic       hunt_vld;
	logic [7:0] hunt_byte;
	hunt_res_t  hres;
	unp_ctl_t   uctl;
	accel_off_t offs_q;
	logic       rx_rdy;

	// offset registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offs_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx_e'(cfg_index))
				CFG_ACCEL_OFF_X: offs_q.x <= cfg_wdata;
				CFG_ACCEL_OFF_Y: offs_q.y <= cfg_wdata;
				CFG_ACCEL_OFF_Z: offs_q.z <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// hold off the closing byte while a result still waits
	assign rx_rdy   = (state_q == ST_RX) && !(frame.valid && hres.at_last);
	assign rx.ready = rx_rdy;

	// hunter takes live bytes or replayed store bytes
	assign hunt_byte = (state_q == ST_RX) ? rx.rx_byte : rd_data;

	// sequencer: next state and store read control
	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		rd_en    = 1'b0;
		hunt_vld = 1'b0;
		uctl     = '0;
		unique case (state_q)
			ST_RX: begin
				hunt_vld = rx.valid && rx_rdy;
				if (hres.done) begin
					idx_d   = SEQ_POS;
					state_d = hres.pass ? ST_UNPACK : ST_REPLAY;
				end
			end
			ST_REPLAY: begin
				rd_en    = 1'b1;
				idx_d    = idx_q + 1'b1;
				hunt_vld = rd_pend_s1;
				if (idx_q == SUM_POS) begin
					state_d = ST_REPLAY_END;
				end
			end
			ST_REPLAY_END: begin
				hunt_vld = rd_pend_s1;
				state_d  = ST_RX;
			end
			ST_UNPACK: begin
				rd_en      = 1'b1;
				idx_d      = idx_q + 1'b1;
				uctl.shift = rd_pend_s1;
				if (idx_q == PAYLOAD_END) begin
					state_d = ST_UNPACK_END;
				end
			end
			ST_UNPACK_END: begin
				uctl.shift = rd_pend_s1;
				uctl.load  = 1'b1;
				state_d    = ST_RX;
			end
			default: begin
				state_d = ST_RX;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_RX;
			idx_q      <= '0;
			rd_pend_s1 <= 1'b0;
		end else begin
			state_q    <= state_d;
			idx_q      <= idx_d;
			rd_pend_s1 <= rd_en;
		end
	end

	imu_dfr_hunter u_hunter (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_vld (hunt_vld),
		.byte_in  (hunt_byte),
		.res      (hres)
	);

	// replay writes always land below the next read address
	imu_dfr_store u_store (
		.clk     (clk),
		.wr_en   (hres.wr_en),
		.wr_addr (hres.wr_addr),
		.wr_data (hres.wr_data),
		.rd_en   (rd_en),
		.rd_addr (idx_q),
		.rd_data (rd_data)
	);

	imu_dfr_unpack u_unpack (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (uctl),
		.rd_data (rd_data),
		.offs    (offs_q),
		.frame   (frame)
	);

endmodule

// File: src/imu_dfr_store.sv
// ----------------------------------------------------------------------------
// imu_dfr_store
// Frame store: 32 x 8 synchronous RAM, one write port and one read port,
// read data registered.
// ----------------------------------------------------------------------------
module imu_dfr_store (
	input  logic                clk,
	input  logic                wr_en,
	input  imu_dfr_pkg::addr_t  wr_addr,
	input  logic [7:0]          wr_data,
	input  logic                rd_en,
	input  imu_dfr_pkg::addr_t  rd_addr,
	output logic [7:0]          rd_data
);
	import imu_dfr_pkg::*;

	logic [7:0] mem_q [FRAME_LEN];
	logic [7:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: src/imu_dfr_hunter.sv
// ----------------------------------------------------------------------------
// imu_dfr_hunter
// Sync hunter: finds 0x55 0xAA, then steers body bytes into the frame store
// and keeps a running 8-bit sum of bytes 2..30 for the byte-31 check.
// ----------------------------------------------------------------------------
module imu_dfr_hunter (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    byte_vld,
	input  logic [7:0]              byte_in,
	output imu_dfr_pkg::hunt_res_t  res
);
	import imu_dfr_pkg::*;

	hunt_phase_e phase_q, phase_d;
	addr_t       fill_q, fill_d;
	logic [7:0]  sum_q, sum_d;

	// next phase, fill position and checksum
	always_comb begin
		phase_d     = phase_q;
		fill_d      = fill_q;
		sum_d       = sum_q;
		res         = '0;
		res.wr_addr = fill_q;
		res.wr_data = byte_in;
		res.at_last = (phase_q == PH_COLLECT) && (fill_q == SUM_POS);
		res.pass    = (sum_q == byte_in);
		if (byte_vld) begin
			unique case (phase_q)
				PH_HUNT: begin
					phase_d = (byte_in == SYNC_FIRST) ? PH_SYNC1 : PH_HUNT;
				end
				PH_SYNC1: begin
					if (byte_in == SYNC_SECOND) begin
						// sync bytes themselves are never read back
						phase_d = PH_COLLECT;
						fill_d  = SEQ_POS;
						sum_d   = '0;
					end else if (byte_in != SYNC_FIRST) begin
						phase_d = PH_HUNT;
					end
				end
				PH_COLLECT: begin
					res.wr_en = 1'b1;
					if (fill_q == SUM_POS) begin
						res.done = 1'b1;
						phase_d  = PH_HUNT;
						fill_d   = '0;
					end else begin
						fill_d = fill_q + 1'b1;
						sum_d  = sum_q + byte_in;
					end
				end
				default: begin
					phase_d = PH_HUNT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			fill_q  <= '0;
			sum_q   <= '0;
		end else begin
			phase_q <= phase_d;
			fill_q  <= fill_d;
			sum_q   <= sum_d;
		end
	end

endmodule

// File: src/imu_dfr_unpack.sv
// ----------------------------------------------------------------------------
// imu_dfr_unpack
// Collects payload bytes 2..30 read from the frame store, splits them into
// little-endian fields, removes the accel offsets, counts lost frames and
// holds the result in the output register until it is taken.
// ----------------------------------------------------------------------------
module imu_dfr_unpack (
	input  logic                    clk,
	input  logic                    arst_n,
	input  imu_dfr_pkg::unp_ctl_t   ctl,
	input  logic [7:0]              rd_data,
	input  imu_dfr_pkg::accel_off_t offs,
	imu_dfr_frame_if.source         frame
);
	import imu_dfr_pkg::*;

	localparam int PAY_W      = PAYLOAD_BYTES * 8;
	// bit offsets inside the payload word (byte 2 at bit 0)
	localparam int GX_LSB     = (3 - 2) * 8;
	localparam int GY_LSB     = (5 - 2) * 8;
	localparam int GZ_LSB     = (7 - 2) * 8;
	localparam int AX_LSB     = (9 - 2) * 8;
	localparam int AY_LSB     = (11 - 2) * 8;
	localparam int AZ_LSB     = (13 - 2) * 8;
	localparam int QW_LSB     = (15 - 2) * 8;
	localparam int QX_LSB     = (19 - 2) * 8;
	localparam int QY_LSB     = (23 - 2) * 8;
	localparam int QZ_LSB     = (27 - 2) * 8;
	// seq + modulus - prev stays below 512; only enough subtract steps to
	// cover the largest quotient are kept
	localparam int DIFF_W     = 11;
	localparam int REM_W      = 18;
	localparam int LOST_STEPS = $clog2((255 + SEQ_MODULUS) / SEQ_MODULUS + 1);

	logic [PAY_W-1:0] pay_q, pay_next;
	logic [7:0]       prev_seq_q;
	logic             prev_vld_q;
	logic [7:0]       seq;
	logic [15:0]      raw_ax, raw_ay, raw_az;
	logic [DIFF_W-1:0] seq_up, diff;
	logic             ahead;
	logic [REM_W-1:0] rem;
	logic [7:0]       lost;

	// payload shifts in oldest byte first
	assign pay_next = {rd_data, pay_q[PAY_W-1:8]};

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			pay_q <= pay_next;
		end
	end

	assign seq    = pay_next[7:0];
	assign raw_ax = pay_next[AX_LSB +: 16];
	assign raw_ay = pay_next[AY_LSB +: 16];
	assign raw_az = pay_next[AZ_LSB +: 16];

	// lost frames: (seq + M - prev) mod M, minus one, by restoring subtracts
	always_comb begin
		seq_up = DIFF_W'({3'b000, seq}) + DIFF_W'(SEQ_MODULUS);
		ahead  = seq_up > DIFF_W'({3'b000, prev_seq_q});
		diff   = seq_up - DIFF_W'({3'b000, prev_seq_q});
		rem    = REM_W'(diff);
		for (int k = LOST_STEPS - 1; k >= 0; k--) begin
			if (rem >= (REM_W'(SEQ_MODULUS) << k)) begin
				rem = rem - (REM_W'(SEQ_MODULUS) << k);
			end
		end
		lost = (prev_vld_q && ahead && (rem != '0)) ? 8'(rem - 1'b1) : 8'd0;
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			frame.frame_seq   <= seq;
			frame.gyro_x      <= pay_next[GX_LSB +: 16];
			frame.gyro_y      <= pay_next[GY_LSB +: 16];
			frame.gyro_z      <= pay_next[GZ_LSB +: 16];
			frame.accel_x     <= $signed({raw_ax[15], raw_ax}) - $signed({offs.x[15], offs.x});
			frame.accel_y     <= $signed({raw_ay[15], raw_ay}) - $signed({offs.y[15], offs.y});
			frame.accel_z     <= $signed({raw_az[15], raw_az}) - $signed({offs.z[15], offs.z});
			frame.quat_w      <= pay_next[QW_LSB +: 32];
			frame.quat_x      <= pay_next[QX_LSB +: 32];
			frame.quat_y      <= pay_next[QY_LSB +: 32];
			frame.quat_z      <= pay_next[QZ_LSB +: 32];
			frame.lost_frames <= lost;
		end
	end

	// output valid and last sequence number
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame.valid <= 1'b0;
			prev_seq_q  <= '0;
			prev_vld_q  <= 1'b0;
		end else if (ctl.load) begin
			frame.valid <= 1'b1;
			prev_seq_q  <= seq;
			prev_vld_q  <= 1'b1;
		end else if (frame.ready) begin
			frame.valid <= 1'b0;
		end
	end

endmodule

// File: src/imu_dfr_checker.sv
// ----------------------------------------------------------------------------
// imu_dfr_props
// Port-level checks of the deframer: output hold, lost count range, and the
// busy windows around frame completion.
// ----------------------------------------------------------------------------
module imu_dfr_props (
	input logic               clk,
	input logic               arst_n,
	input logic               rx_valid,
	input logic               rx_ready,
	input logic               frame_valid,
	input logic               frame_ready,
	input logic [7:0]         frame_seq,
	input logic [7:0]         lost_frames,
	input logic signed [31:0] quat_w
);
	import imu_dfr_pkg::*;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && !frame_ready |=>
			frame_valid && $stable(frame_seq) && $stable(lost_frames) && $stable(quat_w))
		else $error("result changed while stalled");

	// lost count stays below the sequence modulus
	a_lost_range: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid |-> ({1'b0, lost_frames} < 9'(SEQ_MODULUS)))
		else $error("lost frame count out of range");

	// a new result appears only out of the unpack window
	a_rise_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(frame_valid) |-> !$past(rx_ready))
		else $error("result appeared while input was open");

	// input closes only right after a byte transfer
	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(rx_ready) |-> $past(rx_valid && rx_ready))
		else $error("input closed without a byte transfer");

endmodule

bind imu_frame_deframer_top imu_dfr_props u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rx_valid    (rx.valid),
	.rx_ready    (rx.ready),
	.frame_valid (frame.valid),
	.frame_ready (frame.ready),
	.frame_seq   (frame.frame_seq),
	.lost_frames (frame.lost_frames),
	.quat_w      (frame.quat_w)
);

// File: tb/imu_dfr_checker.sv
// ----------------------------------------------------------------------------
// imu_dfr_checker
// Watches the byte and frame channels and the offset write port of the
// deframer. It tracks sync hunting, checksum replay and unpacking on its own,
// queues the frames it expects, and compares every frame transfer field by
// field against the oldest one.
// ----------------------------------------------------------------------------
module imu_dfr_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	imu_dfr_rx_if                              rx,
	imu_dfr_frame_if                           frame,
	input  logic                               cfg_wr_en,
	input  logic [imu_dfr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [imu_dfr_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output int                                 fail_count,
	output int                                 pending
);
	import imu_dfr_pkg::*;

	typedef struct {
		logic [7:0]         seq;
		logic signed [15:0] gx;
		logic signed [15:0] gy;
		logic signed [15:0] gz;
		logic signed [16:0] ax;
		logic signed [16:0] ay;
		logic signed [16:0] az;
		logic signed [31:0] qw;
		logic signed [31:0] qx;
		logic signed [31:0] qy;
		logic signed [31:0] qz;
		logic [7:0]         lost;
	} imu_sample_t;

	imu_sample_t frames_owed [$];
	logic [7:0]  store [FRAME_LEN];
	int          fill     = 0;
	hunt_phase_e phase    = PH_HUNT;
	logic [7:0]  last_seq = '0;
	bit          seq_seen = 1'b0;
	accel_off_t  offs     = '0;
	int          errs     = 0;

	// One byte through the sync hunter; true once 32 bytes are held
	function automatic bit hunt_advance(input logic [7:0] b);
		case (phase)
			PH_COLLECT: begin
				store[fill] = b;
				fill++;
				return fill >= FRAME_LEN;
			end
			PH_SYNC1: begin
				if (b == SYNC_SECOND) begin
					store[0] = SYNC_FIRST;
					store[1] = SYNC_SECOND;
					fill     = 2;
					phase    = PH_COLLECT;
				end else if (b != SYNC_FIRST) begin
					phase = PH_HUNT;
				end
				return 1'b0;
			end
			default: begin
				phase = (b == SYNC_FIRST) ? PH_SYNC1 : PH_HUNT;
				return 1'b0;
			end
		endcase
	endfunction

	// Accepted byte: hunt, check the sum, then replay or unpack
	task automatic deframe_byte(input logic [7:0] b);
		logic [7:0]  sum;
		logic [7:0]  held [FRAME_LEN-2];
		imu_sample_t s;
		int          t;
		if (!hunt_advance(b))
			return;
		sum = '0;
		for (int i = SEQ_POS; i <= PAYLOAD_END; i++)
			sum += store[i];
		if (sum != store[SUM_POS]) begin
			// bad sum: drop the sync pair and rehunt over bytes 2..31
			for (int i = 0; i < FRAME_LEN-2; i++)
				held[i] = store[i+2];
			phase = PH_HUNT;
			fill  = 0;
			foreach (held[i])
				void'(hunt_advance(held[i]));
			return;
		end
		s.seq  = store[SEQ_POS];
		s.gx   = {store[4], store[3]};
		s.gy   = {store[6], store[5]};
		s.gz   = {store[8], store[7]};
		s.ax   = $signed({store[10], store[9]}) - offs.x;
		s.ay   = $signed({store[12], store[11]}) - offs.y;
		s.az   = $signed({store[14], store[13]}) - offs.z;
		s.qw   = {store[18], store[17], store[16], store[15]};
		s.qx   = {store[22], store[21], store[20], store[19]};
		s.qy   = {store[26], store[25], store[24], store[23]};
		s.qz   = {store[30], store[29], store[28], store[27]};
		s.lost = '0;
		// lost count modulo the sequence wrap; zero on the first frame
		if (seq_seen) begin
			t = int'(s.seq) + SEQ_MODULUS - int'(last_seq);
			if (t > 0 && t % SEQ_MODULUS != 0)
				s.lost = 8'(t % SEQ_MODULUS - 1);
		end
		last_seq = s.seq;
		seq_seen = 1'b1;
		frames_owed.push_back(s);
		phase = PH_HUNT;
		fill  = 0;
	endtask

	function automatic int field_diff(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	// Offset writes, frame compare, then byte prediction
	always @(posedge clk) begin
		imu_sample_t want;
		if (arst_n) begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_ACCEL_OFF_X: offs.x = cfg_wdata;
					CFG_ACCEL_OFF_Y: offs.y = cfg_wdata;
					CFG_ACCEL_OFF_Z: offs.z = cfg_wdata;
					default: ;
				endcase
			end
			if (frame.valid && frame.ready) begin
				if (frames_owed.size() == 0) begin
					$error("unexpected frame transfer, frame_seq %0h", frame.frame_seq);
					errs++;
				end else begin
					want = frames_owed.pop_front();
					errs += field_diff("frame_seq", want.seq, frame.frame_seq);
					errs += field_diff("gyro_x", want.gx, frame.gyro_x);
					errs += field_diff("gyro_y", want.gy, frame.gyro_y);
					errs += field_diff("gyro_z", want.gz, frame.gyro_z);
					errs += field_diff("accel_x", want.ax, frame.accel_x);
					errs += field_diff("accel_y", want.ay, frame.accel_y);
					errs += field_diff("accel_z", want.az, frame.accel_z);
					errs += field_diff("quat_w", want.qw, frame.quat_w);
					errs += field_diff("quat_x", want.qx, frame.quat_x);
					errs += field_diff("quat_y", want.qy, frame.quat_y);
					errs += field_diff("quat_z", want.qz, frame.quat_z);
					errs += field_diff("lost_frames", want.lost, frame.lost_frames);
				end
			end
			if (rx.valid && rx.ready)
				deframe_byte(rx.rx_byte);
			pending    <= frames_owed.size();
			fail_count <= errs;
		end
	end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Byte stream stimulus for the IMU frame deframer: directed frames for the
// field extremes, lost-count wrap rules, sync handling and checksum replay,
// then random traffic of good, bad and nested frames plus noise over several
// offset settings and idle patterns. The checker does all comparing.
// ----------------------------------------------------------------------------
module testbench;
	import imu_dfr_pkg::*;

	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES   = 400;
	localparam int QUIET_LIMIT   = 5000;
	localparam int PHASE_BYTES   = 220;
	localparam int N_PHASES      = 6;
	localparam int SEND_IDLE [N_PHASES] = '{0, 77, 0, 38, 0, 38};
	localparam int RECV_STALL [N_PHASES] = '{0, 0, 77, 38, 0, 38};
	// index past the last offset register; the block must ignore it
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

	typedef logic [7:0] frame_t [FRAME_LEN];

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	int                    fail_count;
	int                    pending;
	int                    idle_pct  = 0;
	int                    stall_pct = 0;
	bit                    hold_req  = 1'b0;
	int                    quiet     = 0;
	int                    sent      = 0;
	logic [7:0]            seq_next  = '0;
	frame_t                fbuf;
	frame_t                inner;

	imu_dfr_rx_if    rx ();
	imu_dfr_frame_if frame ();

	imu_frame_deframer_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.frame     (frame),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	imu_dfr_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx),
		.frame      (frame),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Frame receiver: random stalls plus one long hold-off
	initial begin
		int hold_left;
		bit hold_done;
		hold_left   = 0;
		hold_done   = 1'b0;
		frame.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				frame.ready <= 1'b0;
				hold_left--;
			end else if (hold_req && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
				frame.ready <= 1'b0;
			end else begin
				frame.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Watchdog: too long without any transfer ends the run
	always @(posedge clk) begin
		if ((rx.valid && rx.ready) || (frame.valid && frame.ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic push_byte(input logic [7:0] b);
		while ($urandom_range(99) < idle_pct) begin
			rx.valid <= 1'b0;
			@(posedge clk);
		end
		rx.valid   <= 1'b1;
		rx.rx_byte <= b;
		@(posedge clk);
		while (!rx.ready)
			@(posedge clk);
		sent++;
	endtask

	task automatic send_frame(input int n);
		for (int i = 0; i < n; i++)
			push_byte(fbuf[i]);
	endtask

	task automatic fill_body(input logic [7:0] seq);
		fbuf[SEQ_POS] = seq;
		for (int i = 3; i <= PAYLOAD_END; i++)
			fbuf[i] = 8'($urandom);
	endtask

	// Sync pair plus checksum; a bad sum gets one flipped bit
	task automatic seal_frame(input bit good);
		logic [7:0] sum;
		fbuf[0] = SYNC_FIRST;
		fbuf[1] = SYNC_SECOND;
		sum = '0;
		for (int i = SEQ_POS; i <= PAYLOAD_END; i++)
			sum += fbuf[i];
		fbuf[SUM_POS] = good ? sum : sum ^ (8'h01 << $urandom_range(7));
	endtask

	// Bad frame whose body holds the head of a good frame from position pos;
	// the replay finds that sync and the tail bytes then close it
	task automatic send_resync_frame(input logic [7:0] seq, input int pos);
		logic [7:0] sum;
		fill_body(seq);
		seal_frame(1'b1);
		inner = fbuf;
		for (int i = SEQ_POS; i < pos; i++)
			fbuf[i] = 8'($urandom_range(8'h4F));
		for (int i = pos; i < FRAME_LEN; i++)
			fbuf[i] = inner[i-pos];
		sum = '0;
		for (int i = SEQ_POS; i <= PAYLOAD_END; i++)
			sum += fbuf[i];
		if (sum == fbuf[SUM_POS])
			fbuf[SEQ_POS]++;
		send_frame(FRAME_LEN);
		for (int i = FRAME_LEN - pos; i < FRAME_LEN; i++)
			push_byte(inner[i]);
	endtask

	// Stop sending and wait for every owed frame, then let a replay finish
	task automatic drain();
		rx.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_offsets(input logic [15:0] x, input logic [15:0] y,
		input logic [15:0] z, input bit spare);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_ACCEL_OFF_X;
		cfg_wdata <= x;
		@(posedge clk);
		cfg_index <= CFG_ACCEL_OFF_Y;
		cfg_wdata <= y;
		@(posedge clk);
		cfg_index <= CFG_ACCEL_OFF_Z;
		cfg_wdata <= z;
		@(posedge clk);
		if (spare) begin
			cfg_index <= CFG_IDX_SPARE;
			cfg_wdata <= 16'($urandom);
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
	endtask

	// One random chunk of traffic; mostly well-formed frames
	task automatic send_random_unit();
		int         kind;
		logic [7:0] seq;
		kind = $urandom_range(99);
		seq  = $urandom_range(1) ? 8'(seq_next + $urandom_range(3)) : 8'($urandom_range(255));
		seq_next = seq + 8'd1;
		if (kind < 60) begin
			fill_body(seq);
			seal_frame(1'b1);
			send_frame(FRAME_LEN);
		end else if (kind < 72) begin
			fill_body(seq);
			seal_frame(1'b0);
			send_frame(FRAME_LEN);
		end else if (kind < 84) begin
			send_resync_frame(seq, $urandom_range(3, 20));
		end else if (kind < 92) begin
			repeat ($urandom_range(1, 8))
				push_byte($urandom_range(3) == 0 ? SYNC_FIRST : 8'($urandom));
		end else begin
			repeat ($urandom_range(1, 4))
				push_byte(SYNC_FIRST);
			fill_body(seq);
			seal_frame(1'b1);
			send_frame(FRAME_LEN);
		end
	endtask

	initial begin
		int start;
		rx.valid   = 1'b0;
		rx.rx_byte = '0;
		cfg_wr_en  = 1'b0;
		cfg_index  = CFG_ACCEL_OFF_X;
		cfg_wdata  = '0;
		arst_n     = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// false start, then repeated 0x55 ahead of the first frame
		push_byte(SYNC_FIRST);
		push_byte(8'h12);
		push_byte(SYNC_FIRST);
		push_byte(SYNC_FIRST);
		fbuf = '{default: 8'h00};
		fbuf[SEQ_POS] = 8'd10;
		seal_frame(1'b1);
		send_frame(FRAME_LEN);

		// same sequence number again: nothing lost
		fill_body(8'd10);
		seal_frame(1'b1);
		send_frame(FRAME_LEN);

		// all-ones body, sequence number past the wrap
		fbuf = '{default: 8'hFF};
		seal_frame(1'b1);
		send_frame(FRAME_LEN);

		// backward jump, field extremes, sync pair inside the body
		fill_body(8'd5);
		{fbuf[4], fbuf[3]} = 16'h8000;
		{fbuf[6], fbuf[5]} = 16'h7FFF;
		{fbuf[18], fbuf[17], fbuf[16], fbuf[15]} = 32'h8000_0000;
		{fbuf[22], fbuf[21], fbuf[20], fbuf[19]} = 32'h7FFF_FFFF;
		fbuf[23] = SYNC_FIRST;
		fbuf[24] = SYNC_SECOND;
		seal_frame(1'b1);
		send_frame(FRAME_LEN);

		// checksum failure, plain and with a frame hidden in the body
		fill_body(8'd9);
		seal_frame(1'b0);
		send_frame(FRAME_LEN);
		send_resync_frame(8'd6, 10);
		drain();

		// accelerometer extremes against extreme offsets
		load_offsets(16'h7FFF, 16'h8000, 16'hFFFF, 1'b1);
		fill_body(8'd7);
		{fbuf[10], fbuf[9]}  = 16'h8000;
		{fbuf[12], fbuf[11]} = 16'h7FFF;
		{fbuf[14], fbuf[13]} = 16'h0000;
		seal_frame(1'b1);
		send_frame(FRAME_LEN);
		fill_body(8'd8);
		{fbuf[10], fbuf[9]}  = 16'h7FFF;
		{fbuf[12], fbuf[11]} = 16'h8000;
		{fbuf[14], fbuf[13]} = 16'h8000;
		seal_frame(1'b1);
		send_frame(FRAME_LEN);
		drain();

		// random traffic, one offset setting and idle pattern per phase
		for (int ph = 0; ph < N_PHASES; ph++) begin
			case (ph)
				1: load_offsets(16'h8000, 16'h7FFF, 16'h0001, 1'b0);
				3: load_offsets(16'h0000, 16'h0000, 16'h0000, 1'b1);
				5: load_offsets(16'h7FFF, 16'h7FFF, 16'h8000, 1'b0);
				default: load_offsets(16'($urandom), 16'($urandom), 16'($urandom),
					1'($urandom));
			endcase
			idle_pct  = SEND_IDLE[ph];
			stall_pct = RECV_STALL[ph];
			if (ph == 4)
				hold_req = 1'b1;
			start = sent;
			while (sent - start < PHASE_BYTES)
				send_random_unit();
			drain();
		end

		if (fail_count == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
